/* hw/rtl/vmbs_pkg.sv */
`default_nettype none

package vmbs_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int COORD_W     = 32;
  localparam int NUM_COORDS  = 3;
  localparam int NUM_CORNERS = 4;
  localparam int VERTEX_W    = NUM_COORDS * COORD_W;
  localparam int STORE_AW    = 19;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 10;
  localparam int POSX_W      = 18;
  localparam int POSY_W      = 17;
  localparam int COL_W       = POSX_W - FRAC_BITS;
  localparam int ROW_W       = POSY_W - FRAC_BITS;
  localparam int WGT_W       = 2 * FRAC_BITS + 1;
  localparam int PROD_W      = COORD_W + WGT_W + 1;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PAIR_W + 1;
  localparam int MIN_DIM     = 2;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 512;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [COORD_W-1:0] MINUS_ONE_Q16 = 32'hFFFF_0000;
  localparam logic [SUM_W-1:0]   ROUND_BIAS    = SUM_W'(1) << (2 * FRAC_BITS - 1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                               ok;
    logic [NUM_CORNERS-1:0][WGT_W-1:0] wgt;
  } query_t;

endpackage

`default_nettype wire

/* hw/rtl/vmbs_ram.sv */
`default_nettype none

module vmbs_ram #(
  parameter int ADDR_W = 19,
  parameter int DATA_W = 96
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [DATA_W-1:0] rd_data_a,
  output logic      [DATA_W-1:0] rd_data_b
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vmbs_addr.sv */
`default_nettype none

module vmbs_addr (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [vmbs_pkg::POSX_W-1:0]   in_pos_x,
  input  wire logic [vmbs_pkg::POSY_W-1:0]   in_pos_y,
  input  wire logic [vmbs_pkg::WIDTH_W-1:0]  w_use,
  input  wire logic [vmbs_pkg::HEIGHT_W-1:0] h_use,
  input  wire logic                          down_ready,
  output logic                               s1_valid,
  output vmbs_pkg::query_t                   s1_q,
  output logic [vmbs_pkg::STORE_AW-1:0]      addr0,
  output logic [vmbs_pkg::STORE_AW-1:0]      addr1,
  output logic [vmbs_pkg::STORE_AW-1:0]      addr2,
  output logic [vmbs_pkg::STORE_AW-1:0]      addr3
);

  import vmbs_pkg::*;

  logic                  v1_r;
  logic                  v1_nxt;
  logic [STORE_AW-1:0]   base_r;
  logic [STORE_AW-1:0]   base_nxt;
  query_t                q1_r;
  query_t                q1_nxt;
  logic                  load;
  logic [COL_W-1:0]      px;
  logic [ROW_W-1:0]      py;
  logic [FRAC_BITS-1:0]  fx;
  logic [FRAC_BITS-1:0]  fy;
  logic [FRAC_BITS:0]    hx [2];
  logic [FRAC_BITS:0]    hy [2];
  logic [2*FRAC_BITS+1:0] wfull [NUM_CORNERS];
  logic [STORE_AW:0]     row_base;
  logic [STORE_AW:0]     base_full;

  assign in_ready = !v1_r || down_ready;
  assign load     = in_valid && in_ready;

  assign px = in_pos_x[POSX_W-1:FRAC_BITS];
  assign py = in_pos_y[POSY_W-1:FRAC_BITS];
  assign fx = in_pos_x[FRAC_BITS-1:0];
  assign fy = in_pos_y[FRAC_BITS-1:0];

  always_comb begin
    hx[0] = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx};
    hx[1] = {1'b0, fx};
    hy[0] = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy};
    hy[1] = {1'b0, fy};
    for (int k = 0; k < NUM_CORNERS; k++) begin
      wfull[k] = (2*FRAC_BITS+2)'(hx[k % 2]) * (2*FRAC_BITS+2)'(hy[k / 2]);
    end
    row_base  = (STORE_AW+1)'(py) * (STORE_AW+1)'(w_use);
    base_full = row_base + (STORE_AW+1)'(px);
    base_nxt  = base_full[STORE_AW-1:0];
    q1_nxt.ok = ((WIDTH_W'(px) + WIDTH_W'(1)) < w_use) &&
                ((HEIGHT_W'(py) + HEIGHT_W'(1)) < h_use);
    for (int k = 0; k < NUM_CORNERS; k++) begin
      q1_nxt.wgt[k] = wfull[k][WGT_W-1:0];
    end
    v1_nxt = v1_r;
    if (in_ready) begin
      v1_nxt = load && (in_cmd == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base_r <= base_nxt;
      q1_r   <= q1_nxt;
    end
  end

  assign s1_valid = v1_r;
  assign s1_q     = q1_r;
  assign addr0    = base_r;
  assign addr1    = base_r + STORE_AW'(1);
  assign addr2    = base_r + STORE_AW'(w_use);
  assign addr3    = addr2 + STORE_AW'(1);

endmodule

`default_nettype wire

/* hw/rtl/vmbs_blend.sv */
`default_nettype none

module vmbs_blend (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  output logic                               s1_ready,
  input  wire vmbs_pkg::query_t              s1_q,
  input  wire logic [vmbs_pkg::VERTEX_W-1:0] crn0,
  input  wire logic [vmbs_pkg::VERTEX_W-1:0] crn1,
  input  wire logic [vmbs_pkg::VERTEX_W-1:0] crn2,
  input  wire logic [vmbs_pkg::VERTEX_W-1:0] crn3,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [vmbs_pkg::COORD_W-1:0] out_res_x,
  output logic signed [vmbs_pkg::COORD_W-1:0] out_res_y,
  output logic signed [vmbs_pkg::COORD_W-1:0] out_res_z,
  output logic                               out_res_valid
);

  import vmbs_pkg::*;

  logic                      v2_r, v3_r, v4_r, out_valid_r;
  logic                      v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic                      rdy2, rdy3, rdy4, rdy_o;
  query_t                    q2_r;
  logic                      ok3_r, ok4_r, out_ok_r;
  logic                      ok3_nxt;
  logic signed [PROD_W-1:0]  prod_r   [NUM_COORDS][NUM_CORNERS];
  logic signed [PROD_W-1:0]  prod_nxt [NUM_COORDS][NUM_CORNERS];
  logic signed [PAIR_W-1:0]  pair_r   [NUM_COORDS][2];
  logic signed [PAIR_W-1:0]  pair_nxt [NUM_COORDS][2];
  logic [SUM_W-1:0]          total    [NUM_COORDS];
  logic [COORD_W-1:0]        res_nxt  [NUM_COORDS];
  logic [COORD_W-1:0]        res_r    [NUM_COORDS];
  logic [NUM_CORNERS-1:0][VERTEX_W-1:0] crn;

  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy4     = !v4_r || rdy_o;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  assign crn = {crn3, crn2, crn1, crn0};

  always_comb begin
    ok3_nxt = q2_r.ok;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      if (crn[k][VERTEX_W-1]) begin
        ok3_nxt = 1'b0;
      end
    end
    for (int c = 0; c < NUM_COORDS; c++) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        prod_nxt[c][k] = PROD_W'($signed(crn[k][c*COORD_W +: COORD_W])) *
                         PROD_W'($signed({1'b0, q2_r.wgt[k]}));
      end
      pair_nxt[c][0] = {prod_r[c][0][PROD_W-1], prod_r[c][0]} +
                       {prod_r[c][1][PROD_W-1], prod_r[c][1]};
      pair_nxt[c][1] = {prod_r[c][2][PROD_W-1], prod_r[c][2]} +
                       {prod_r[c][3][PROD_W-1], prod_r[c][3]};
      total[c] = {pair_r[c][0][PAIR_W-1], pair_r[c][0]} +
                 {pair_r[c][1][PAIR_W-1], pair_r[c][1]} + ROUND_BIAS;
      res_nxt[c] = ok4_r ? total[c][2*FRAC_BITS +: COORD_W] : '0;
    end
    if (!ok4_r) begin
      res_nxt[NUM_COORDS-1] = MINUS_ONE_Q16;
    end
    v2_nxt        = rdy2 ? s1_valid : v2_r;
    v3_nxt        = rdy3 ? v2_r : v3_r;
    v4_nxt        = rdy4 ? v3_r : v4_r;
    out_valid_nxt = rdy_o ? v4_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && rdy2) begin
      q2_r <= s1_q;
    end
    if (v2_r && rdy3) begin
      ok3_r  <= ok3_nxt;
      prod_r <= prod_nxt;
    end
    if (v3_r && rdy4) begin
      ok4_r  <= ok3_r;
      pair_r <= pair_nxt;
    end
    if (v4_r && rdy_o) begin
      out_ok_r <= ok4_r;
      res_r    <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_x     = res_r[0];
  assign out_res_y     = res_r[1];
  assign out_res_z     = res_r[2];
  assign out_res_valid = out_ok_r;

`ifndef NO_ASSERTIONS
  a_invalid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |->
      (res_r[0] == '0 && res_r[1] == '0 && res_r[2] == MINUS_ONE_Q16))
    else $error("invalid result not in canonical form");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && rdy2) |=> v2_r)
    else $error("memory read issued without capture stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy_o) |=> (v4_r && $stable(ok4_r)))
    else $error("stalled sum stage lost its item");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vertex_map_bilinear_sampler_unit.sv */
// A query goes through the address, read, product, pair and output registers.
// Throughput: one item per cycle while in_ready is high; writes and queries may be mixed freely.
// The four corners come from two copies of the vertex store, each read at two ports.
// Reset (rst_n low, synchronous): pipeline emptied, width 640, height 480.
// Vertex store contents are undefined after reset; no clearing pass.
`default_nettype none

module vertex_map_bilinear_sampler_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_cmd,
  input  wire logic [vmbs_pkg::STORE_AW-1:0]   in_pixel_index,
  input  wire logic signed [vmbs_pkg::COORD_W-1:0] in_vertex_x,
  input  wire logic signed [vmbs_pkg::COORD_W-1:0] in_vertex_y,
  input  wire logic signed [vmbs_pkg::COORD_W-1:0] in_vertex_z,
  input  wire logic [vmbs_pkg::POSX_W-1:0]     in_pos_x,
  input  wire logic [vmbs_pkg::POSY_W-1:0]     in_pos_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [vmbs_pkg::COORD_W-1:0]  out_res_x,
  output logic signed [vmbs_pkg::COORD_W-1:0]  out_res_y,
  output logic signed [vmbs_pkg::COORD_W-1:0]  out_res_z,
  output logic                                 out_res_valid,
  input  wire logic                            cfg_wr_en,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [vmbs_pkg::WIDTH_W-1:0]    cfg_data
);

  import vmbs_pkg::*;

  logic [WIDTH_W-1:0]  img_width_r,  img_width_nxt;
  logic [HEIGHT_W-1:0] img_height_r, img_height_nxt;
  logic [WIDTH_W-1:0]  w_use;
  logic [HEIGHT_W-1:0] h_use;
  logic                wr_en;
  logic [VERTEX_W-1:0] wr_data;
  logic                rd_en;
  logic                s1_valid;
  logic                s2_ready;
  query_t              s1_q;
  logic [STORE_AW-1:0] addr0, addr1, addr2, addr3;
  logic [VERTEX_W-1:0] crn0, crn1, crn2, crn3;

  always_comb begin
    img_width_nxt  = img_width_r;
    img_height_nxt = img_height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_width_nxt  = cfg_data;
        REG_IMAGE_HEIGHT: img_height_nxt = cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_W'(RESET_WIDTH);
      img_height_r <= HEIGHT_W'(RESET_HEIGHT);
    end else begin
      img_width_r  <= img_width_nxt;
      img_height_r <= img_height_nxt;
    end
  end

  assign w_use = (img_width_r < WIDTH_W'(MIN_DIM))   ? WIDTH_W'(MIN_DIM)   :
                 (img_width_r > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : img_width_r;
  assign h_use = (img_height_r < HEIGHT_W'(MIN_DIM))    ? HEIGHT_W'(MIN_DIM)    :
                 (img_height_r > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) :
                 img_height_r;

  assign wr_en   = in_valid && in_ready && (in_cmd == CMD_WRITE);
  assign wr_data = {in_vertex_z, in_vertex_y, in_vertex_x};
  assign rd_en   = s1_valid && s2_ready;

  vmbs_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .w_use      (w_use),
    .h_use      (h_use),
    .down_ready (s2_ready),
    .s1_valid   (s1_valid),
    .s1_q       (s1_q),
    .addr0      (addr0),
    .addr1      (addr1),
    .addr2      (addr2),
    .addr3      (addr3)
  );

  vmbs_ram #(
    .ADDR_W (STORE_AW),
    .DATA_W (VERTEX_W)
  ) u_ram_top (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (in_pixel_index),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (addr0),
    .rd_addr_b (addr1),
    .rd_data_a (crn0),
    .rd_data_b (crn1)
  );

  vmbs_ram #(
    .ADDR_W (STORE_AW),
    .DATA_W (VERTEX_W)
  ) u_ram_bot (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (in_pixel_index),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (addr2),
    .rd_addr_b (addr3),
    .rd_data_a (crn2),
    .rd_data_b (crn3)
  );

  vmbs_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_ready      (s2_ready),
    .s1_q          (s1_q),
    .crn0          (crn0),
    .crn1          (crn1),
    .crn2          (crn2),
    .crn3          (crn3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res_x     (out_res_x),
    .out_res_y     (out_res_y),
    .out_res_z     (out_res_z),
    .out_res_valid (out_res_valid)
  );

endmodule

`default_nettype wire
